### rtl/core/opportunistic_etx_three_forwarders_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the opportunistic etx core
// each macro expands to one labelled concurrent assertion on clk / rst_n
// ----------------------------------------------------------------------------
`ifndef OPPORTUNISTIC_ETX_THREE_FORWARDERS_CORE_ASSERT_SVH
`define OPPORTUNISTIC_ETX_THREE_FORWARDERS_CORE_ASSERT_SVH

// same-cycle implication
`define OETX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oetx assertion failed");

// next-cycle implication
`define OETX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oetx assertion failed");

`endif

### rtl/core/oetx_pkg.sv
// ----------------------------------------------------------------------------
// oetx_pkg
// shared constants and types of the opportunistic etx core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oetx_pkg;

    localparam int PROB_FRAC_BITS_DEF = 16;
    localparam int OUT_FRAC_BITS      = 16;
    localparam int OUT_W              = 40;
    localparam int NUM_IN_FIELDS      = 10;
    localparam int NUM_REGIONS        = 7;
    localparam int NUM_TERMS          = 12;
    localparam int SUM_W              = OUT_W + 4;

    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    // term slots feeding the dividers
    localparam int T_BASE = 0;
    localparam int T_REG0 = 1;   // latency terms of the seven regions start here
    localparam int T_RES0 = 8;   // duplex resource terms of the four shared regions

    // input field slots
    localparam int F_P1   = 0;
    localparam int F_P2   = 1;
    localparam int F_P3   = 2;
    localparam int F_P12  = 3;
    localparam int F_P13  = 4;
    localparam int F_P23  = 5;
    localparam int F_P123 = 6;
    localparam int F_D1   = 7;
    localparam int F_D2   = 8;
    localparam int F_D3   = 9;

    // region slots
    localparam int R_O1   = 0;
    localparam int R_O2   = 1;
    localparam int R_O3   = 2;
    localparam int R_O12  = 3;
    localparam int R_O13  = 4;
    localparam int R_O23  = 5;
    localparam int R_O123 = 6;

    // register index of duplex_mode, taken from paddr[2]
    localparam logic REG_DUPLEX = 1'b0;

    typedef struct packed {
        logic duplex;
        logic unreach;
        logic inf;
    } ctrl_t;

endpackage

### rtl/core/oetx_front.sv
// ----------------------------------------------------------------------------
// oetx_front
// regions, union probabilities, per-term numerators and denominators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oetx_front #(
    parameter int PROB_FRAC_BITS = oetx_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  en,
    input  logic                                                  in_valid,
    input  logic [oetx_pkg::NUM_IN_FIELDS-1:0][PROB_FRAC_BITS:0]  fields,
    input  logic                                                  duplex,
    output logic                                                  out_valid,
    output oetx_pkg::ctrl_t                                       out_ctrl,
    output logic [oetx_pkg::NUM_TERMS-1:0][2*PROB_FRAC_BITS+19:0] out_num,
    output logic [oetx_pkg::NUM_TERMS-1:0][2*PROB_FRAC_BITS:0]    out_den
);

    localparam int F     = PROB_FRAC_BITS;
    localparam int IN_W  = F + 1;
    localparam int SW    = F + 5;
    localparam int R_W   = F + 2;
    localparam int DEN_W = 2 * F + 1;
    localparam int NUM_W = 2 * F + 20;
    localparam int SHIFT = F + oetx_pkg::OUT_FRAC_BITS;
    localparam int NR    = oetx_pkg::NUM_REGIONS;

    localparam logic [IN_W-1:0]   ONE   = {1'b1, {F{1'b0}}};
    localparam logic signed [SW-1:0] ONE_S = $signed(SW'(ONE));

    // stage 1: regions, divisor, clamped delivery probabilities
    logic [NR-1:0][R_W-1:0] s1_r_reg, s1_r_next;
    logic [IN_W-1:0]        s1_d_reg, s1_d_next;
    logic [2:0][IN_W-1:0]   s1_q_reg, s1_q_next;
    logic [2:0][IN_W-1:0]   s1_n_reg, s1_n_next;
    oetx_pkg::ctrl_t        s1_ctrl_reg, s1_ctrl_next;
    logic                   s1_valid_reg;

    always_comb
    begin
        logic signed [SW-1:0] sp [7];
        logic signed [SW-1:0] v  [NR];
        logic signed [SW-1:0] none_v;
        for (int i = 0; i < 7; i++)
        begin
            sp[i] = $signed(SW'(fields[i]));
        end
        v[oetx_pkg::R_O1]   = sp[oetx_pkg::F_P1] - sp[oetx_pkg::F_P12]
                            - sp[oetx_pkg::F_P13] + sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O2]   = sp[oetx_pkg::F_P2] - sp[oetx_pkg::F_P12]
                            - sp[oetx_pkg::F_P23] + sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O3]   = sp[oetx_pkg::F_P3] - sp[oetx_pkg::F_P13]
                            - sp[oetx_pkg::F_P23] + sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O12]  = sp[oetx_pkg::F_P12] - sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O13]  = sp[oetx_pkg::F_P13] - sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O23]  = sp[oetx_pkg::F_P23] - sp[oetx_pkg::F_P123];
        v[oetx_pkg::R_O123] = sp[oetx_pkg::F_P123];
        none_v = ONE_S - (sp[oetx_pkg::F_P1] + sp[oetx_pkg::F_P2] + sp[oetx_pkg::F_P3])
               + (sp[oetx_pkg::F_P12] + sp[oetx_pkg::F_P13] + sp[oetx_pkg::F_P23])
               - sp[oetx_pkg::F_P123];
        for (int i = 0; i < NR; i++)
        begin
            s1_r_next[i] = v[i][SW-1] ? '0 : v[i][R_W-1:0];
        end
        s1_ctrl_next.duplex  = duplex;
        s1_ctrl_next.unreach = !none_v[SW-1] && (none_v >= ONE_S);
        s1_ctrl_next.inf     = 1'b0;
        if (s1_ctrl_next.unreach)
        begin
            s1_d_next = IN_W'(1);
        end
        else if (none_v[SW-1])
        begin
            s1_d_next = ONE;
        end
        else
        begin
            s1_d_next = ONE - none_v[IN_W-1:0];
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_q_next[i] = (fields[oetx_pkg::F_D1 + i] > ONE) ? ONE : fields[oetx_pkg::F_D1 + i];
            s1_n_next[i] = ONE - s1_q_next[i];
        end
    end

    // stage 2: pairwise miss products
    logic [NR-1:0][R_W-1:0] s2_r_reg;
    logic [IN_W-1:0]        s2_d_reg;
    logic [2:0][IN_W-1:0]   s2_q_reg;
    logic [IN_W-1:0]        s2_nc_reg;
    logic [2:0][IN_W-1:0]   s2_m_reg, s2_m_next;   // ab, ac, bc
    oetx_pkg::ctrl_t        s2_ctrl_reg;
    logic                   s2_valid_reg;

    always_comb
    begin
        logic [2*IN_W-1:0] pab, pac, pbc;
        pab = s1_n_reg[0] * s1_n_reg[1];
        pac = s1_n_reg[0] * s1_n_reg[2];
        pbc = s1_n_reg[1] * s1_n_reg[2];
        s2_m_next[0] = pab[F +: IN_W];
        s2_m_next[1] = pac[F +: IN_W];
        s2_m_next[2] = pbc[F +: IN_W];
    end

    // stage 3: pair delivery choice and triple miss product
    logic [NR-1:0][R_W-1:0] s3_r_reg;
    logic [IN_W-1:0]        s3_d_reg;
    logic [2:0][IN_W-1:0]   s3_q_reg;
    logic [2:0][IN_W-1:0]   s3_p_reg, s3_p_next;   // q12, q13, q23
    logic [IN_W-1:0]        s3_m3_reg, s3_m3_next;
    oetx_pkg::ctrl_t        s3_ctrl_reg;
    logic                   s3_valid_reg;

    always_comb
    begin
        logic [2*IN_W-1:0] pabc;
        logic [IN_W-1:0]   mx12, mx13, mx23;
        pabc = s2_m_reg[0] * s2_nc_reg;
        s3_m3_next = pabc[F +: IN_W];
        mx12 = (s2_q_reg[0] > s2_q_reg[1]) ? s2_q_reg[0] : s2_q_reg[1];
        mx13 = (s2_q_reg[0] > s2_q_reg[2]) ? s2_q_reg[0] : s2_q_reg[2];
        mx23 = (s2_q_reg[1] > s2_q_reg[2]) ? s2_q_reg[1] : s2_q_reg[2];
        s3_p_next[0] = s2_ctrl_reg.duplex ? ONE - s2_m_reg[0] : mx12;
        s3_p_next[1] = s2_ctrl_reg.duplex ? ONE - s2_m_reg[1] : mx13;
        s3_p_next[2] = s2_ctrl_reg.duplex ? ONE - s2_m_reg[2] : mx23;
    end

    // stage 4: all delivery probabilities per region, infinite-cost flag
    logic [NR-1:0][R_W-1:0]  s4_r_reg;
    logic [IN_W-1:0]         s4_d_reg;
    logic [NR-1:0][IN_W-1:0] s4_q_reg, s4_q_next;
    oetx_pkg::ctrl_t         s4_ctrl_reg, s4_ctrl_next;
    logic                    s4_valid_reg;

    always_comb
    begin
        logic [IN_W-1:0] mx3;
        logic            inf;
        mx3 = (s3_q_reg[0] > s3_q_reg[1]) ? s3_q_reg[0] : s3_q_reg[1];
        mx3 = (mx3 > s3_q_reg[2]) ? mx3 : s3_q_reg[2];
        s4_q_next[oetx_pkg::R_O1]   = s3_q_reg[0];
        s4_q_next[oetx_pkg::R_O2]   = s3_q_reg[1];
        s4_q_next[oetx_pkg::R_O3]   = s3_q_reg[2];
        s4_q_next[oetx_pkg::R_O12]  = s3_p_reg[0];
        s4_q_next[oetx_pkg::R_O13]  = s3_p_reg[1];
        s4_q_next[oetx_pkg::R_O23]  = s3_p_reg[2];
        s4_q_next[oetx_pkg::R_O123] = s3_ctrl_reg.duplex ? ONE - s3_m3_reg : mx3;
        inf = 1'b0;
        for (int i = 0; i < NR; i++)
        begin
            inf = inf | ((s3_r_reg[i] != '0) && (s4_q_next[i] == '0));
        end
        s4_ctrl_next     = s3_ctrl_reg;
        s4_ctrl_next.inf = inf;
    end

    // stage 5: denominators q*d and shifted numerators
    logic [oetx_pkg::NUM_TERMS-1:0][NUM_W-1:0] s5_num_reg, s5_num_next;
    logic [oetx_pkg::NUM_TERMS-1:0][DEN_W-1:0] s5_den_reg, s5_den_next;
    oetx_pkg::ctrl_t                           s5_ctrl_reg;
    logic                                      s5_valid_reg;

    always_comb
    begin
        logic [2*IN_W-1:0] prod;
        logic              zero;
        logic [NUM_W-1:0]  rs;
        s5_num_next = '0;
        s5_den_next = '0;
        s5_num_next[oetx_pkg::T_BASE] = NUM_W'(1) << SHIFT;
        s5_den_next[oetx_pkg::T_BASE] = DEN_W'(s4_d_reg);
        for (int i = 0; i < NR; i++)
        begin
            prod = s4_q_reg[i] * s4_d_reg;
            zero = (s4_r_reg[i] == '0) || (s4_q_reg[i] == '0);
            rs   = NUM_W'(s4_r_reg[i]) << SHIFT;
            s5_num_next[oetx_pkg::T_REG0 + i] = zero ? '0 : rs;
            s5_den_next[oetx_pkg::T_REG0 + i] = zero ? DEN_W'(1) : prod[DEN_W-1:0];
            if (i >= oetx_pkg::R_O12)
            begin
                // resource weight: two forwarders for a pair, three for all
                s5_num_next[oetx_pkg::T_RES0 + i - oetx_pkg::R_O12] =
                    zero ? '0 : ((i == oetx_pkg::R_O123) ? rs + (rs << 1) : rs << 1);
                s5_den_next[oetx_pkg::T_RES0 + i - oetx_pkg::R_O12] =
                    zero ? DEN_W'(1) : prod[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_r_reg    <= s1_r_next;
            s1_d_reg    <= s1_d_next;
            s1_q_reg    <= s1_q_next;
            s1_n_reg    <= s1_n_next;
            s1_ctrl_reg <= s1_ctrl_next;

            s2_r_reg    <= s1_r_reg;
            s2_d_reg    <= s1_d_reg;
            s2_q_reg    <= s1_q_reg;
            s2_nc_reg   <= s1_n_reg[2];
            s2_m_reg    <= s2_m_next;
            s2_ctrl_reg <= s1_ctrl_reg;

            s3_r_reg    <= s2_r_reg;
            s3_d_reg    <= s2_d_reg;
            s3_q_reg    <= s2_q_reg;
            s3_p_reg    <= s3_p_next;
            s3_m3_reg   <= s3_m3_next;
            s3_ctrl_reg <= s2_ctrl_reg;

            s4_r_reg    <= s3_r_reg;
            s4_d_reg    <= s3_d_reg;
            s4_q_reg    <= s4_q_next;
            s4_ctrl_reg <= s4_ctrl_next;

            s5_num_reg  <= s5_num_next;
            s5_den_reg  <= s5_den_next;
            s5_ctrl_reg <= s4_ctrl_reg;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_ctrl  = s5_ctrl_reg;
    assign out_num   = s5_num_reg;
    assign out_den   = s5_den_reg;

endmodule

### rtl/core/oetx_div.sv
// ----------------------------------------------------------------------------
// oetx_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oetx_div #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [DEN_W-1:0] rem_reg [NUM_W-1];
    logic [DEN_W-1:0] dv_reg  [NUM_W-1];
    logic [NUM_W-1:0] nq_reg  [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DEN_W-1:0] rem_i;
        logic [DEN_W-1:0] den_i;
        logic [NUM_W-1:0] nq_i;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0)
        begin : g_first
            assign rem_i = '0;
            assign den_i = den;
            assign nq_i  = num;
        end
        else
        begin : g_next
            assign rem_i = rem_reg[k-1];
            assign den_i = dv_reg[k-1];
            assign nq_i  = nq_reg[k-1];
        end

        // quotient bits shift in from the bottom as numerator bits leave the top
        assign trial = {rem_i, nq_i[NUM_W-1]};
        assign diff  = trial - {1'b0, den_i};
        assign take  = trial >= {1'b0, den_i};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nq_reg[k] <= {nq_i[NUM_W-2:0], take};
            end
        end

        if (k < NUM_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                    dv_reg[k]  <= den_i;
                end
            end
        end
    end

    assign quo = nq_reg[NUM_W-1];

endmodule

### rtl/core/oetx_sum.sv
// ----------------------------------------------------------------------------
// oetx_sum
// saturating sum of the divided terms, final clamping and flags
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oetx_sum #(
    parameter int QW = 52
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  oetx_pkg::ctrl_t                           in_ctrl,
    input  logic [oetx_pkg::NUM_TERMS-1:0][QW-1:0]    quo,
    output logic                                      out_valid,
    output logic [oetx_pkg::OUT_W-1:0]                out_lat,
    output logic [oetx_pkg::OUT_W-1:0]                out_res,
    output logic                                      out_unreach,
    output logic                                      out_sat
);

    localparam int OW = oetx_pkg::OUT_W;
    localparam int TW = OW + 1;
    localparam int SW = oetx_pkg::SUM_W;

    // each term is clamped to one past the maximum before summing
    logic [oetx_pkg::NUM_TERMS-1:0][TW-1:0] t;

    for (genvar i = 0; i < oetx_pkg::NUM_TERMS; i++)
    begin : g_clamp
        if (QW > OW)
        begin : g_wide
            assign t[i] = (quo[i][QW-1:OW] != '0) ? {1'b1, {OW{1'b0}}} : {1'b0, quo[i][OW-1:0]};
        end
        else
        begin : g_narrow
            assign t[i] = TW'(quo[i]);
        end
    end

    logic [SW-1:0]   x1_com_reg, x1_lat_reg, x1_res_reg;
    oetx_pkg::ctrl_t x1_ctrl_reg;
    logic            x1_valid_reg;

    logic [OW-1:0]   x2_lat_reg, x2_lat_next;
    logic [OW-1:0]   x2_res_reg, x2_res_next;
    logic            x2_unreach_reg, x2_sat_reg, x2_sat_next;
    logic            x2_valid_reg;

    always_comb
    begin
        logic [SW-1:0] lat_full, res_full;
        logic          ov_l, ov_r;
        lat_full = x1_com_reg + x1_lat_reg;
        res_full = x1_com_reg + (x1_ctrl_reg.duplex ? x1_res_reg : x1_lat_reg);
        ov_l = lat_full > SW'(oetx_pkg::OUT_MAX);
        ov_r = res_full > SW'(oetx_pkg::OUT_MAX);
        if (x1_ctrl_reg.unreach)
        begin
            x2_lat_next = oetx_pkg::OUT_MAX;
            x2_res_next = oetx_pkg::OUT_MAX;
            x2_sat_next = 1'b0;
        end
        else
        begin
            x2_lat_next = (x1_ctrl_reg.inf || ov_l) ? oetx_pkg::OUT_MAX : lat_full[OW-1:0];
            x2_res_next = (x1_ctrl_reg.inf || ov_r) ? oetx_pkg::OUT_MAX : res_full[OW-1:0];
            x2_sat_next = x1_ctrl_reg.inf || ov_l || ov_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_valid_reg <= 1'b0;
            x2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            x1_valid_reg <= in_valid;
            x2_valid_reg <= x1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_com_reg <= SW'(t[oetx_pkg::T_BASE]) + SW'(t[oetx_pkg::T_REG0])
                        + SW'(t[oetx_pkg::T_REG0+1]) + SW'(t[oetx_pkg::T_REG0+2]);
            x1_lat_reg <= SW'(t[oetx_pkg::T_REG0+3]) + SW'(t[oetx_pkg::T_REG0+4])
                        + SW'(t[oetx_pkg::T_REG0+5]) + SW'(t[oetx_pkg::T_REG0+6]);
            x1_res_reg <= SW'(t[oetx_pkg::T_RES0]) + SW'(t[oetx_pkg::T_RES0+1])
                        + SW'(t[oetx_pkg::T_RES0+2]) + SW'(t[oetx_pkg::T_RES0+3]);
            x1_ctrl_reg <= in_ctrl;

            x2_lat_reg     <= x2_lat_next;
            x2_res_reg     <= x2_res_next;
            x2_sat_reg     <= x2_sat_next;
            x2_unreach_reg <= x1_ctrl_reg.unreach;
        end
    end

    assign out_valid   = x2_valid_reg;
    assign out_lat     = x2_lat_reg;
    assign out_res     = x2_res_reg;
    assign out_unreach = x2_unreach_reg;
    assign out_sat     = x2_sat_reg;

endmodule

### rtl/core/opportunistic_etx_three_forwarders_core.sv
// ----------------------------------------------------------------------------
// opportunistic_etx_three_forwarders_core
// expected transmission counts for one source, three forwarders, one sink
// ----------------------------------------------------------------------------
// s_* stream: one transaction carries the ten link probabilities of one
// candidate set, packed 17 bits each (PROB_FRAC_BITS + 1) from p_src_f1 up.
// m_* stream: one transaction per input, latency and resource etx (Q24.16)
// in tdata, unreachable and saturated flags in tuser.
// apb port: duplex_mode at address 0, written in the access phase.
// pipeline: the front-end stages, then the bit-per-stage dividers, one per
// term, then the summing stages and the output register that drives m_tvalid.
// throughput: one transaction per clock unless stalled; all twelve dividers run in parallel.
// stalls: valid bits move with the data; when the output register is full
// and not taken, the pipeline freezes only once its last stage holds a
// result, so bubbles are squeezed out and nothing is dropped or repeated.
// reset: all valid bits clear, duplex_mode returns to full duplex.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module opportunistic_etx_three_forwarders_core #(
    parameter int PROB_FRAC_BITS = oetx_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    // p_src_f1, p_src_f2, p_src_f3, p_src_f12, p_src_f13, p_src_f23,
    // p_src_f123, p_f1_dst, p_f2_dst, p_f3_dst, zero padding
    input  logic [((oetx_pkg::NUM_IN_FIELDS*(PROB_FRAC_BITS+1)+7)/8)*8-1:0] s_tdata,
    input  logic                                                      s_tvalid,
    output logic                                                      s_tready,
    // latency_etx, resource_etx
    output logic [2*oetx_pkg::OUT_W-1:0]                              m_tdata,
    // unreachable, saturated
    output logic [1:0]                                                m_tuser,
    output logic                                                      m_tvalid,
    input  logic                                                      m_tready,
    input  logic                                                      psel,
    input  logic                                                      penable,
    input  logic                                                      pwrite,
    input  logic [2:0]                                                paddr,
    input  logic [31:0]                                               pwdata,
    output logic [31:0]                                               prdata,
    output logic                                                      pready
);

    localparam int F     = PROB_FRAC_BITS;
    localparam int IN_W  = F + 1;
    localparam int NUM_W = 2 * F + 20;
    localparam int DEN_W = 2 * F + 1;
    localparam int OW    = oetx_pkg::OUT_W;
    localparam int NT    = oetx_pkg::NUM_TERMS;

    // configuration
    logic duplex_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == oetx_pkg::REG_DUPLEX) ? {31'd0, duplex_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duplex_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == oetx_pkg::REG_DUPLEX))
        begin
            duplex_reg <= pwdata[0];
        end
    end

    // pipeline advance
    logic en;
    logic last_valid;
    logic out_valid_reg;

    assign en       = !(last_valid && out_valid_reg && !m_tready);
    assign s_tready = en;

    logic [oetx_pkg::NUM_IN_FIELDS-1:0][IN_W-1:0] fields;

    for (genvar i = 0; i < oetx_pkg::NUM_IN_FIELDS; i++)
    begin : g_unpack
        assign fields[i] = s_tdata[i*IN_W +: IN_W];
    end

    logic                     fr_valid;
    oetx_pkg::ctrl_t          fr_ctrl;
    logic [NT-1:0][NUM_W-1:0] fr_num;
    logic [NT-1:0][DEN_W-1:0] fr_den;

    oetx_front #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .fields    (fields),
        .duplex    (duplex_reg),
        .out_valid (fr_valid),
        .out_ctrl  (fr_ctrl),
        .out_num   (fr_num),
        .out_den   (fr_den)
    );

    logic [NT-1:0][NUM_W-1:0] quo;

    for (genvar i = 0; i < NT; i++)
    begin : g_div
        oetx_div #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .clk (clk),
            .en  (en),
            .num (fr_num[i]),
            .den (fr_den[i]),
            .quo (quo[i])
        );
    end

    // control travelling alongside the divider stages
    logic            side_valid_reg [NUM_W];
    oetx_pkg::ctrl_t side_ctrl_reg  [NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                side_valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            side_valid_reg[0] <= fr_valid;
            for (int k = 1; k < NUM_W; k++)
            begin
                side_valid_reg[k] <= side_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_ctrl_reg[0] <= fr_ctrl;
            for (int k = 1; k < NUM_W; k++)
            begin
                side_ctrl_reg[k] <= side_ctrl_reg[k-1];
            end
        end
    end

    logic          sm_valid;
    logic [OW-1:0] sm_lat, sm_res;
    logic          sm_unreach, sm_sat;

    oetx_sum #(
        .QW (NUM_W)
    ) u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (side_valid_reg[NUM_W-1]),
        .in_ctrl     (side_ctrl_reg[NUM_W-1]),
        .quo         (quo),
        .out_valid   (sm_valid),
        .out_lat     (sm_lat),
        .out_res     (sm_res),
        .out_unreach (sm_unreach),
        .out_sat     (sm_sat)
    );

    assign last_valid = sm_valid;

    // output register
    logic [OW-1:0] out_lat_reg, out_res_reg;
    logic          out_unreach_reg, out_sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (last_valid && en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_valid && en)
        begin
            out_lat_reg     <= sm_lat;
            out_res_reg     <= sm_res;
            out_unreach_reg <= sm_unreach;
            out_sat_reg     <= sm_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg, out_lat_reg};
    assign m_tuser  = {out_sat_reg, out_unreach_reg};

    logic lat_max, res_max;

    assign lat_max = (out_lat_reg == oetx_pkg::OUT_MAX);
    assign res_max = (out_res_reg == oetx_pkg::OUT_MAX);

`include "opportunistic_etx_three_forwarders_core_assert.svh"

    `OETX_ASSERT_NOW(a_unreach_max, out_valid_reg && out_unreach_reg, lat_max && res_max && !out_sat_reg)
    `OETX_ASSERT_NOW(a_sat_clamped, out_valid_reg && out_sat_reg, lat_max || res_max)
    `OETX_ASSERT_NEXT(a_stall_holds_end, !en, last_valid && out_valid_reg)

endmodule
